// File: rtl/iba_pkg.sv
`timescale 1ns / 1ps
package iba_pkg;

   localparam int INODE_COUNT    = 64;
   localparam int DIRECT_SLOTS   = 12;
   localparam int INDIRECT_SLOTS = 1024;
   localparam int BLOCK_COUNT    = 32768;

   localparam int MAP_ROW   = DIRECT_SLOTS + 1;
   localparam int DIR_DEPTH = INODE_COUNT * MAP_ROW;
   localparam int DIR_AW    = $clog2(DIR_DEPTH);
   localparam int IND_DEPTH = INODE_COUNT * INDIRECT_SLOTS;
   localparam int IND_AW    = $clog2(IND_DEPTH);

   localparam int INO_W     = 6;
   localparam int LB_W      = 12;
   localparam int TYPE_W    = 2;
   localparam int BLK_W     = 15;
   localparam int CNT_W     = 16;
   localparam int INO_CNT_W = 7;
   localparam int STAT_W    = 2;
   localparam int ALLOC_W   = 2;
   localparam int CSR_IW    = 2;
   localparam int CSR_DW    = 16;

   localparam logic [LB_W-1:0] LB_DIRECT = LB_W'(DIRECT_SLOTS);
   localparam logic [LB_W-1:0] LB_LIMIT  = LB_W'(DIRECT_SLOTS + INDIRECT_SLOTS);

   localparam logic [CSR_IW-1:0] REG_FIRST_DATA_BLOCK = 2'd0;
   localparam logic [CSR_IW-1:0] REG_BLOCK_LIMIT      = 2'd1;
   localparam logic [CSR_IW-1:0] REG_INODE_LIMIT      = 2'd2;

   localparam logic [BLK_W-1:0]     FIRST_DATA_BLOCK_RST = 15'd64;
   localparam logic [CNT_W-1:0]     BLOCK_LIMIT_RST      = 16'd32768;
   localparam logic [INO_CNT_W-1:0] INODE_LIMIT_RST      = 7'd64;
   localparam logic [INO_CNT_W-1:0] NEXT_INODE_RST       = 7'd1;

   typedef enum logic [STAT_W-1:0] {
      ST_OK,
      ST_NO_BLOCK,
      ST_NO_INODE,
      ST_TOO_LARGE
   } status_type;

   typedef enum logic {
      KIND_INODE,
      KIND_MAP
   } kind_type;

   typedef struct packed {
      logic                 reload;
      logic [CNT_W-1:0]     reload_value;
      logic [CNT_W-1:0]     block_lim;
      logic [INO_CNT_W-1:0] inode_lim;
   } cfg_type;

   function automatic logic [CNT_W-1:0] block_start(input logic [BLK_W-1:0] v);
      block_start = (v == '0) ? CNT_W'(1) : CNT_W'(v);
   endfunction

endpackage

// File: rtl/iba_req_if.sv
`timescale 1ns / 1ps
interface iba_req_if;
   import iba_pkg::*;

   logic              valid;
   logic              ready;
   logic              kind;
   logic [INO_W-1:0]  inode_number;
   logic [LB_W-1:0]   logical_block;
   logic [TYPE_W-1:0] file_type;

   modport source (output valid, kind, inode_number, logical_block, file_type, input ready);
   modport sink (input valid, kind, inode_number, logical_block, file_type, output ready);
endinterface

// File: rtl/iba_rsp_if.sv
`timescale 1ns / 1ps
interface iba_rsp_if;
   import iba_pkg::*;

   logic               valid;
   logic               ready;
   logic [STAT_W-1:0]  status;
   logic [BLK_W-1:0]   result_number;
   logic [ALLOC_W-1:0] blocks_allocated;

   modport source (output valid, status, result_number, blocks_allocated, input ready);
   modport sink (input valid, status, result_number, blocks_allocated, output ready);
endinterface

// File: rtl/iba_csr_if.sv
`timescale 1ns / 1ps
interface iba_csr_if;
   import iba_pkg::*;

   logic              valid;
   logic              ready;
   logic [CSR_IW-1:0] index;
   logic [CSR_DW-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// File: rtl/iba_ram.sv
`timescale 1ns / 1ps
module iba_ram #(
   parameter int WIDTH = 15,
   parameter int DEPTH = 1024,
   localparam int AW   = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/iba_csr.sv
`timescale 1ns / 1ps
module iba_csr (
   input  logic             clock,
   input  logic             reset,
   iba_csr_if.sink          csr_ch,
   output iba_pkg::cfg_type cfg
);
   import iba_pkg::*;

   logic [CNT_W-1:0]     block_limit_ff;
   logic [INO_CNT_W-1:0] inode_limit_ff;
   logic                 wr;

   assign csr_ch.ready = 1'b1;
   assign wr           = csr_ch.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_limit_ff      <= BLOCK_LIMIT_RST;
         inode_limit_ff      <= INODE_LIMIT_RST;
      end else if (wr) begin
         unique case (csr_ch.index)
            REG_FIRST_DATA_BLOCK: ;
            REG_BLOCK_LIMIT:      block_limit_ff      <= csr_ch.data[CNT_W-1:0];
            REG_INODE_LIMIT:      inode_limit_ff      <= csr_ch.data[INO_CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      cfg.reload       = wr && (csr_ch.index == REG_FIRST_DATA_BLOCK);
      cfg.reload_value = block_start(csr_ch.data[BLK_W-1:0]);
      cfg.block_lim    = (block_limit_ff < CNT_W'(BLOCK_COUNT)) ?
                         block_limit_ff : CNT_W'(BLOCK_COUNT);
      cfg.inode_lim    = (inode_limit_ff < INO_CNT_W'(INODE_COUNT)) ?
                         inode_limit_ff : INO_CNT_W'(INODE_COUNT);
   end

endmodule

// File: rtl/iba_map.sv
`timescale 1ns / 1ps
module iba_map (
   input  logic             clock,
   input  logic             reset,
   input  iba_pkg::cfg_type cfg,
   iba_req_if.sink          req_ch,
   iba_rsp_if.source        rsp_ch
);
   import iba_pkg::*;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EVAL,
      S_DONE
   } state_type;

   state_type            state_ff;
   logic [IND_AW-1:0]    clr_cnt_ff;
   logic [CNT_W-1:0]     nb_ff;
   logic [INO_CNT_W-1:0] nfi_ff;
   logic                 is_direct_ff;
   logic [DIR_AW-1:0]    dir_addr_ff;
   logic [IND_AW-1:0]    ind_addr_ff;
   status_type           res_status_ff;
   logic [BLK_W-1:0]     res_number_ff;
   logic [ALLOC_W-1:0]   res_count_ff;
   logic                 rsp_valid_ff;
   status_type           rsp_status_ff;
   logic [BLK_W-1:0]     rsp_number_ff;
   logic [ALLOC_W-1:0]   rsp_count_ff;

   logic                 clearing;
   logic                 req_fire;
   logic                 req_direct;
   logic [LB_W-1:0]      req_slot;
   logic [DIR_AW-1:0]    dir_rd_addr;
   logic [IND_AW-1:0]    ind_rd_addr;

   logic                 dir_we;
   logic [DIR_AW-1:0]    dir_waddr;
   logic [BLK_W-1:0]     dir_wdata;
   logic [BLK_W-1:0]     dir_rdata;
   logic                 ind_we;
   logic [IND_AW-1:0]    ind_waddr;
   logic [BLK_W-1:0]     ind_wdata;
   logic [BLK_W-1:0]     ind_rdata;

   logic                 dir_zero;
   logic                 ind_zero;
   logic [ALLOC_W-1:0]   need;
   logic [CNT_W:0]       nb_sum;
   logic [CNT_W-1:0]     nb_tail;
   logic                 ev_dir_we;
   logic                 ev_ind_we;
   logic [CNT_W-1:0]     ev_nb;
   status_type           ev_status;
   logic [BLK_W-1:0]     ev_number;
   logic [ALLOC_W-1:0]   ev_count;

   assign clearing = (state_ff == S_CLEAR);
   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_fire = req_ch.valid && (state_ff == S_IDLE);

   assign req_direct  = req_ch.logical_block < LB_DIRECT;
   assign req_slot    = req_ch.logical_block - LB_DIRECT;
   assign dir_rd_addr = req_direct ?
                        DIR_AW'(req_ch.inode_number * MAP_ROW + req_ch.logical_block) :
                        DIR_AW'(req_ch.inode_number * MAP_ROW + DIRECT_SLOTS);
   assign ind_rd_addr = IND_AW'(req_ch.inode_number * INDIRECT_SLOTS + req_slot);

   iba_ram #(.WIDTH(BLK_W), .DEPTH(DIR_DEPTH)) u_dir_ram (
      .clock   (clock),
      .wr_en   (dir_we),
      .wr_addr (dir_waddr),
      .wr_data (dir_wdata),
      .rd_en   (req_fire),
      .rd_addr (dir_rd_addr),
      .rd_data (dir_rdata)
   );

   iba_ram #(.WIDTH(BLK_W), .DEPTH(IND_DEPTH)) u_ind_ram (
      .clock   (clock),
      .wr_en   (ind_we),
      .wr_addr (ind_waddr),
      .wr_data (ind_wdata),
      .rd_en   (req_fire),
      .rd_addr (ind_rd_addr),
      .rd_data (ind_rdata)
   );

   always_comb begin
      dir_zero  = (dir_rdata == '0);
      ind_zero  = (ind_rdata == '0);
      need      = ALLOC_W'(dir_zero) + ALLOC_W'(ind_zero);
      nb_sum    = {1'b0, nb_ff} + (CNT_W + 1)'(need);
      nb_tail   = nb_ff + CNT_W'(dir_zero);
      ev_dir_we = 1'b0;
      ev_ind_we = 1'b0;
      ev_nb     = nb_ff;
      ev_status = ST_OK;
      ev_number = '0;
      ev_count  = '0;
      if (is_direct_ff) begin
         priority if (!dir_zero) begin
            ev_number = dir_rdata;
         end else if (nb_ff >= cfg.block_lim) begin
            ev_status = ST_NO_BLOCK;
         end else begin
            ev_dir_we = 1'b1;
            ev_nb     = nb_ff + CNT_W'(1);
            ev_number = nb_ff[BLK_W-1:0];
            ev_count  = ALLOC_W'(1);
         end
      end else begin
         if ((need != '0) && (nb_sum > {1'b0, cfg.block_lim})) begin
            ev_status = ST_NO_BLOCK;
         end else begin
            ev_dir_we = dir_zero;
            ev_ind_we = ind_zero;
            ev_nb     = nb_sum[CNT_W-1:0];
            ev_number = ind_zero ? nb_tail[BLK_W-1:0] : ind_rdata;
            ev_count  = need;
         end
      end
   end

   always_comb begin
      if (clearing) begin
         dir_we    = clr_cnt_ff < IND_AW'(DIR_DEPTH);
         dir_waddr = clr_cnt_ff[DIR_AW-1:0];
         dir_wdata = '0;
         ind_we    = 1'b1;
         ind_waddr = clr_cnt_ff;
         ind_wdata = '0;
      end else begin
         dir_we    = ev_dir_we && (state_ff == S_EVAL);
         dir_waddr = dir_addr_ff;
         dir_wdata = nb_ff[BLK_W-1:0];
         ind_we    = ev_ind_we && (state_ff == S_EVAL);
         ind_waddr = ind_addr_ff;
         ind_wdata = nb_tail[BLK_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_cnt_ff   <= '0;
         nb_ff        <= block_start(FIRST_DATA_BLOCK_RST);
         nfi_ff       <= NEXT_INODE_RST;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ch.ready && (state_ff != S_DONE)) begin
            rsp_valid_ff <= 1'b0;
         end
         if (cfg.reload) begin
            nb_ff <= cfg.reload_value;
         end else if (state_ff == S_EVAL) begin
            nb_ff <= ev_nb;
         end
         unique case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + IND_AW'(1);
               if (clr_cnt_ff == IND_AW'(IND_DEPTH - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_ch.valid) begin
                  is_direct_ff <= req_direct;
                  dir_addr_ff  <= dir_rd_addr;
                  ind_addr_ff  <= ind_rd_addr;
                  res_number_ff <= '0;
                  res_count_ff  <= '0;
                  priority if (req_ch.kind == KIND_INODE) begin
                     state_ff <= S_DONE;
                     if (nfi_ff >= cfg.inode_lim) begin
                        res_status_ff <= ST_NO_INODE;
                     end else begin
                        res_status_ff <= ST_OK;
                        res_number_ff <= BLK_W'(nfi_ff);
                        nfi_ff        <= nfi_ff + INO_CNT_W'(1);
                     end
                  end else if (req_ch.logical_block >= LB_LIMIT) begin
                     state_ff      <= S_DONE;
                     res_status_ff <= ST_TOO_LARGE;
                  end else begin
                     state_ff <= S_EVAL;
                  end
               end
            end
            S_EVAL: begin
               res_status_ff <= ev_status;
               res_number_ff <= ev_number;
               res_count_ff  <= ev_count;
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ch.ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  rsp_number_ff <= res_number_ff;
                  rsp_count_ff  <= res_count_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.status           = rsp_status_ff;
   assign rsp_ch.result_number    = rsp_number_ff;
   assign rsp_ch.blocks_allocated = rsp_count_ff;

endmodule

// File: rtl/inode_block_map_allocator.sv
`timescale 1ns / 1ps
// Inode allocator and per-inode block map. Each request item either takes the
// next inode number (kind 0) or translates a file-relative block index of an
// inode to a physical block (kind 1), taking missing blocks, and the indirect
// table's own block when it is first needed, from a bump allocator. One result
// item comes back per request, in order. A failing request changes no state.
// The file type of a new inode is accepted but not kept, as nothing reads it.
// After reset the block sweeps both map memories to zero, one entry a cycle;
// requests wait during the sweep, register writes do not.
// Requests are served one at a time: an inode allocation or a lookup with an
// out-of-range index goes from idle straight to the state that loads the
// result register; any other block lookup first reads the direct and indirect
// map memories and then passes the evaluate-and-write-back state.
// A finished result waits in that register while the next request is taken.
module inode_block_map_allocator (
   input logic       clock,
   input logic       reset,
   iba_req_if.sink   req_ch,
   iba_rsp_if.source rsp_ch,
   iba_csr_if.sink   csr_ch
);
   import iba_pkg::*;

   cfg_type cfg;

   iba_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   iba_map u_map (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

endmodule
